// ===== rtl/xbg_pkg.sv =====
// Shared types, constants and helpers for the xoshiro128++ block generator.
// No dependencies; used by the controller, the datapath and the top level.
package xbg_pkg;

    // Operation codes carried on s_tuser
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    // Block size default and the cap on words per block
    localparam int BLOCK_BYTES_DEF = 32;
    localparam int MAX_WORDS       = 8;

    // Widths of the stream payloads
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 40;

    // splitmix32 constants
    localparam logic [31:0] SM_GOLDEN = 32'h9E37_79B9;
    localparam logic [31:0] SM_MUL1   = 32'h21F0_AAAD;
    localparam logic [31:0] SM_MUL2   = 32'h735A_2D97;

    // xoshiro128++ rotate and shift amounts
    localparam int XO_ROT_RES = 7;
    localparam int XO_ROT_S3  = 11;
    localparam int XO_SHIFT   = 9;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_seed;  // fold entropy fields into the seed accumulator
        logic       mul_first;  // advance accumulator, first splitmix multiply
        logic       mul_second; // second splitmix multiply
        logic       mix;        // xor finished splitmix output into one state word
        logic       fix;        // force word 0 to one if the state is all zero
        logic       gen;        // advance xoshiro and load the output register
        logic [1:0] round;      // state word addressed by mix
        logic [2:0] word_idx;   // position of the generated word in the block
        logic       last;       // generated word closes the block
    } xbg_cmd_t;

    // Rotate left by a constant amount (1..31)
    function automatic logic [31:0] rotl(input logic [31:0] v, input int amt);
        rotl = (v << amt) | (v >> (32 - amt));
    endfunction

endpackage

// ===== rtl/xbg_ctrl.sv =====
// Sequencer for the xoshiro128++ block generator: input handshake, seed rounds,
// word counting and output valid. Depends on xbg_pkg.
module xbg_ctrl #(
    parameter int BLOCK_BYTES = xbg_pkg::BLOCK_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_op,
    output logic             m_tvalid,
    input  logic             m_tready,
    output xbg_pkg::xbg_cmd_t cmd
);

    localparam int NWORDS_RAW = BLOCK_BYTES / 4;
    localparam int NWORDS = (NWORDS_RAW > xbg_pkg::MAX_WORDS) ? xbg_pkg::MAX_WORDS
                                                                : NWORDS_RAW;
    localparam logic [2:0] LAST_IDX = 3'(NWORDS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL1 = 6'b000010,
        ST_MUL2 = 6'b000100,
        ST_MIX  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_GEN  = 6'b100000
    } xbg_state_t;

    xbg_state_t state_reg, state_next;
    logic [1:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = ~valid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    // Decode state into commands and next state
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        word_next  = word_reg;
        valid_next = valid_reg & ~m_tready;
        cmd            = '0;
        cmd.round      = round_reg;
        cmd.word_idx   = word_reg;
        cmd.last       = (word_reg == LAST_IDX);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    round_next = 2'd0;
                    word_next  = 3'd0;
                    if (s_op == xbg_pkg::OP_SEED) begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_MUL1;
                    end else begin
                        state_next = ST_GEN;
                    end
                end
            end
            ST_MUL1: begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_second = 1'b1;
                state_next     = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                round_next = round_reg + 2'd1;
                state_next = (round_reg == 2'd3) ? ST_FIX : ST_MUL1;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_GEN: begin
                // Hold while the output register is still full
                if (out_free) begin
                    cmd.gen    = 1'b1;
                    valid_next = 1'b1;
                    word_next  = word_reg + 3'd1;
                    if (word_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= 2'd0;
            word_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/xbg_datapath.sv =====
// Datapath of the xoshiro128++ block generator: seed accumulator, shared
// splitmix multiplier, 128-bit state and output payload register. Depends on xbg_pkg.
module xbg_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  xbg_pkg::xbg_cmd_t                 cmd,
    input  logic [xbg_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic [xbg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    logic [31:0] acc_reg, acc_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] gs_reg [4];
    logic [31:0] gs_next [4];
    logic [31:0] word_reg, word_next;
    logic [2:0]  idx_reg;
    logic        last_reg;
    logic [31:0] entropy;
    logic [31:0] mul_a, mul_b;
    logic [31:0] mix_out;
    logic [31:0] adv_res, adv_sh, t2, t3, t1, t0;

    // Fold the entropy fields into one seed word
    assign entropy = s_tdata[31:0] ^ {16'h0000, s_tdata[47:32]} ^ s_tdata[79:48]
                   ^ s_tdata[111:80] ^ s_tdata[143:112];

    // Shared splitmix multiplier
    always_comb begin
        acc_next = acc_reg;
        if (cmd.load_seed) begin
            acc_next = entropy;
        end else if (cmd.mul_first) begin
            acc_next = acc_reg + xbg_pkg::SM_GOLDEN;
        end
        if (cmd.mul_first) begin
            mul_a = acc_next ^ (acc_next >> 16);
            mul_b = xbg_pkg::SM_MUL1;
        end else begin
            mul_a = prod_reg ^ (prod_reg >> 15);
            mul_b = xbg_pkg::SM_MUL2;
        end
        prod_next = prod_reg;
        if (cmd.mul_first || cmd.mul_second) begin
            prod_next = mul_a * mul_b;
        end
    end

    assign mix_out = prod_reg ^ (prod_reg >> 15);

    // One xoshiro128++ step
    always_comb begin
        adv_res = xbg_pkg::rotl(gs_reg[0] + gs_reg[3], xbg_pkg::XO_ROT_RES) + gs_reg[0];
        adv_sh  = gs_reg[1] << xbg_pkg::XO_SHIFT;
        t2      = gs_reg[2] ^ gs_reg[0];
        t3      = gs_reg[3] ^ gs_reg[1];
        t1      = gs_reg[1] ^ t2;
        t0      = gs_reg[0] ^ t3;
    end

    // Update the generator state
    always_comb begin
        gs_next = gs_reg;
        if (cmd.mix) begin
            gs_next[cmd.round] = gs_reg[cmd.round] ^ mix_out;
        end else if (cmd.fix) begin
            if ((gs_reg[0] | gs_reg[1] | gs_reg[2] | gs_reg[3]) == 32'h0) begin
                gs_next[0] = 32'h0000_0001;
            end
        end else if (cmd.gen) begin
            gs_next[0] = t0;
            gs_next[1] = t1;
            gs_next[2] = t2 ^ adv_sh;
            gs_next[3] = xbg_pkg::rotl(t3, xbg_pkg::XO_ROT_S3);
        end
    end

    assign word_next = cmd.gen ? adv_res : word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                gs_reg[i] <= 32'h0;
            end
        end else begin
            gs_reg <= gs_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        word_reg <= word_next;
        if (cmd.gen) begin
            idx_reg  <= cmd.word_idx;
            last_reg <= cmd.last;
        end
    end

    assign m_tdata = {5'b00000, idx_reg, word_reg};
    assign m_tlast = last_reg;

endmodule

// ===== rtl/xoshiro128pp_block_generator_core.sv =====
// xoshiro128++ block generator with splitmix32 seeding.
// Seed item: accepted in idle, then 4 rounds of two multiplies on the
// shared multiplier and one state xor, plus a zero check; busy until it is done.
// Generate item: the generate state then loads one word per cycle into the output
// register while it is free (BLOCK_BYTES/4 words, at most 8), held back while m_tready
// stalls a waiting word; ready again once the last word is loaded.
// Reset (aresetn low, synchronous) clears the 128-bit state and the output valid.
module xoshiro128pp_block_generator_core #(
    parameter int BLOCK_BYTES = xbg_pkg::BLOCK_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tick_count[31:0], adc_average[47:32], uid_word0[79:48],
    // uid_word1[111:80], uid_word2[143:112]
    input  logic [xbg_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // random_word[31:0], word_index[34:32], zero fill[39:35]
    output logic [xbg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int NWORDS_RAW = BLOCK_BYTES / 4;
    localparam int NWORDS = (NWORDS_RAW > xbg_pkg::MAX_WORDS) ? xbg_pkg::MAX_WORDS
                                                                : NWORDS_RAW;
    localparam logic [2:0] LAST_IDX = 3'(NWORDS - 1);

    xbg_pkg::xbg_cmd_t cmd;

    xbg_ctrl #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_op    (s_tuser[0]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    xbg_datapath u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .s_tdata(s_tdata),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // Never overwrite a beat that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.gen)
        else $error("output beat overwritten while stalled");

    // No generation while a new item can be taken
    a_gen_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gen |-> !s_tready)
        else $error("generation while input ready");

    // The flagged beat sits at the last position of the block
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == LAST_IDX)))
        else $error("tlast does not match word index");

    // A seed item is followed by the seed sequence, not by generation
    a_seed_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == xbg_pkg::OP_SEED) |=> cmd.mul_first)
        else $error("seed item did not start splitmix rounds");

endmodule
